// ----- rtl/dpq_pkg.sv -----
// dpq_pkg: shared types and codes for the deduplicating priority queue
`timescale 1ns / 1ps
`default_nettype none
package dpq_pkg;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // field widths
    localparam int ID_W   = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic execute;
    } t_ctrl;

endpackage
`default_nettype wire

// ----- rtl/dpq_ctrl.sv -----
// dpq_ctrl: sequencer for capture, compare and execute of one transaction
`timescale 1ns / 1ps
`default_nettype none
module dpq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    output dpq_pkg::t_ctrl o_ctrl,
    output logic           o_valid
);
    import dpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   accept;

    // a new transaction may enter while the previous one executes
    assign busy   = (r_state == S_CMP);
    assign accept = start && !busy;

    // command decode
    assign o_ctrl.load    = accept;
    assign o_ctrl.compare = (r_state == S_CMP);
    assign o_ctrl.execute = (r_state == S_EXEC);
    assign o_valid        = r_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_EXEC;
            S_EXEC:  n_state = accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EXEC);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dpq_datapath.sv -----
// dpq_datapath: sorted cell chain with per-cell compare, insert and shift
`timescale 1ns / 1ps
`default_nettype none
module dpq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dpq_pkg::t_ctrl               i_ctrl,
    input  wire                          i_func,
    input  wire  [dpq_pkg::ID_W-1:0]     i_item_id,
    input  wire  [dpq_pkg::PRIO_W-1:0]   i_item_priority,
    output logic [1:0]                   o_status,
    output logic [dpq_pkg::ID_W-1:0]     o_out_id,
    output logic [dpq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [dpq_pkg::OCC_W-1:0]    o_occupancy
);
    import dpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // captured transaction
    logic              r_func;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;

    // cell chain, slot 0 is the head
    logic [ID_W-1:0]   r_cell_id   [DEPTH];
    logic [PRIO_W-1:0] r_cell_prio [DEPTH];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // per-cell compare results
    logic [DEPTH-1:0]  r_match;
    logic [DEPTH-1:0]  r_ge;

    // result registers
    logic [1:0]        r_status;
    logic [ID_W-1:0]   r_out_id;
    logic [PRIO_W-1:0] r_out_prio;
    logic [CW-1:0]     r_out_count;

    logic dup;
    logic full;
    logic empty;
    logic do_insert;
    logic do_remove;
    logic [1:0] status;

    assign dup   = |r_match;
    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // status decision, duplicate is checked before fullness
    always_comb begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        status    = ST_DONE;
        priority if (r_func == FUNC_DEQ) begin
            if (empty) begin
                status = ST_EMPTY;
            end else begin
                do_remove = 1'b1;
            end
        end else if (dup) begin
            status = ST_DUP;
        end else if (full) begin
            status = ST_FULL;
        end else begin
            do_insert = 1'b1;
        end
    end

    // entry count update
    always_comb begin
        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CW'(1);
        end else if (do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_func <= i_func;
            r_id   <= i_item_id;
            r_prio <= i_item_priority;
        end
    end

    // compare every held cell against the captured identifier and priority
    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (CW'(i) < r_count) && (r_cell_id[i] == r_id);
                r_ge[i]    <= (CW'(i) < r_count) && (r_cell_prio[i] >= r_prio);
            end
        end
    end

    // insert behind every entry of greater or equal priority, or shift toward head
    always_ff @(posedge i_clk) begin
        if (i_ctrl.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (do_insert && !r_ge[i]) begin
                    if (i == 0) begin
                        r_cell_id[i]   <= r_id;
                        r_cell_prio[i] <= r_prio;
                    end else if (r_ge[i-1]) begin
                        r_cell_id[i]   <= r_id;
                        r_cell_prio[i] <= r_prio;
                    end else begin
                        r_cell_id[i]   <= r_cell_id[i-1];
                        r_cell_prio[i] <= r_cell_prio[i-1];
                    end
                end else if (do_remove && (i < DEPTH - 1)) begin
                    r_cell_id[i]   <= r_cell_id[i+1];
                    r_cell_prio[i] <= r_cell_prio[i+1];
                end
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.execute) begin
            r_count <= n_count;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.execute) begin
            r_status    <= status;
            r_out_id    <= do_remove ? r_cell_id[0]   : '0;
            r_out_prio  <= do_remove ? r_cell_prio[0] : '0;
            r_out_count <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = OCC_W'(r_out_count);

endmodule
`default_nettype wire

// ----- rtl/dedup_priority_queue_top.sv -----
// dedup_priority_queue_top: deduplicating sorted priority queue, top level
// result path: the transaction is captured, compared in the cell chain, then executed;
// o_valid is registered from the execute step; a new transaction may enter while the
// previous one executes, and busy is high only in the compare cycle
// reset: synchronous active-low i_rst_n empties the queue and clears the sequencer
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module dedup_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_func,
    input  wire  [dpq_pkg::ID_W-1:0]     i_item_id,
    input  wire  [dpq_pkg::PRIO_W-1:0]   i_item_priority,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [dpq_pkg::ID_W-1:0]     o_out_id,
    output logic [dpq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [dpq_pkg::OCC_W-1:0]    o_occupancy
);
    import dpq_pkg::*;

    t_ctrl ctrl;

    // sequencer
    dpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (ctrl),
        .o_valid (o_valid)
    );

    // cell chain and result registers
    dpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_func          (i_func),
        .i_item_id       (i_item_id),
        .i_item_priority (i_item_priority),
        .o_status        (o_status),
        .o_out_id        (o_out_id),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    // compare step lasts exactly one cycle
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // every accepted transaction yields a result marked by o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted transaction produced no result");

    // execute is always preceded by compare
    a_exec_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.execute |-> $past(ctrl.compare))
        else $error("execute without compare");

    // an empty dequeue returns zero payload and zero occupancy
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |->
            ((o_occupancy == '0) && (o_out_id == '0) && (o_out_priority == '0)))
        else $error("empty dequeue with nonzero fields");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// testbench: self-checking random and directed test of the deduplicating priority queue
`timescale 1ns / 1ps
module testbench;
    import dpq_pkg::*;

    localparam int DEPTH = 16;

    // one queue command and the idle cycles the driver waits before launching it
    typedef struct {
        logic              func;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                gap;
    } t_command;

    // one result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              i_func = FUNC_ENQ;
    logic [ID_W-1:0]   i_item_id = '0;
    logic [PRIO_W-1:0] i_item_priority = '0;
    logic              busy;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_out_id;
    logic [PRIO_W-1:0] o_out_priority;
    logic [OCC_W-1:0]  o_occupancy;

    t_command command_queue[$];
    t_reply   awaited_replies[$];
    t_command launched_cmd;
    int       idle_waited = 0;
    int       fail_count = 0;

    // shadow copy of the ordered entries, slot 0 is the head
    logic [ID_W-1:0]   held_ids[DEPTH];
    logic [PRIO_W-1:0] held_prios[DEPTH];
    int                held_count = 0;

    dedup_priority_queue_top #(.DEPTH(DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_item_id       (i_item_id),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_id        (o_out_id),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // apply one command to the shadow queue and return the result it should give
    function automatic t_reply serve_command(t_command c);
        t_reply r;
        int     pos;
        bit     dup;
        r = '0;
        dup = 1'b0;
        if (c.func == FUNC_ENQ) begin
            for (int k = 0; k < held_count; k++)
                if (held_ids[k] == c.id) dup = 1'b1;
            if (dup) begin
                r.status = ST_DUP;
            end else if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_count && held_prios[pos] >= c.prio) pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_ids[k]   = held_ids[k-1];
                    held_prios[k] = held_prios[k-1];
                end
                held_ids[pos]   = c.id;
                held_prios[pos] = c.prio;
                held_count++;
                r.status = ST_DONE;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.id   = held_ids[0];
            r.prio = held_prios[0];
            for (int k = 1; k < held_count; k++) begin
                held_ids[k-1]   = held_ids[k];
                held_prios[k-1] = held_prios[k];
            end
            held_count--;
            r.status = ST_DONE;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    task automatic add_cmd(logic func, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                           int gap);
        t_command c;
        c.func = func;
        c.id   = id;
        c.prio = prio;
        c.gap  = gap;
        command_queue.push_back(c);
    endtask

    // driver: launch commands from the queue, hold start until accepted
    always @(posedge i_clk) begin : driver
        logic accepted;
        logic start_next;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                awaited_replies.push_back(serve_command(launched_cmd));
                idle_waited = 0;
            end
            start_next = 1'b0;
            if (start && !accepted) begin
                start_next = 1'b1;
            end else if (command_queue.size() > 0) begin
                if (idle_waited >= command_queue[0].gap) begin
                    launched_cmd = command_queue.pop_front();
                    i_func          <= launched_cmd.func;
                    i_item_id       <= launched_cmd.id;
                    i_item_priority <= launched_cmd.prio;
                    start_next = 1'b1;
                end else begin
                    idle_waited++;
                end
            end
            start <= start_next;
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (awaited_replies.size() == 0) begin
                $error("unexpected result: status %0d id %h prio %0d occupancy %0d",
                       o_status, o_out_id, o_out_priority, o_occupancy);
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_out_id !== want.id) begin
                    $error("out_id: expected %h actual %h", want.id, o_out_id);
                    fail_count++;
                end
                if (o_out_priority !== want.prio) begin
                    $error("out_priority: expected %0d actual %0d", want.prio,
                           o_out_priority);
                    fail_count++;
                end
                if (o_occupancy !== want.occ) begin
                    $error("occupancy: expected %0d actual %0d", want.occ, o_occupancy);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [PRIO_W-1:0] fill_prios[16];
        logic [ID_W-1:0]   id_pool[24];
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                total;
        int                phase_len;
        int                enq_pct;
        bit                no_idle;
        fill_prios = '{0, 255, 128, 128, 255, 0, 64, 128, 1, 254, 128, 0, 255, 32, 128, 16};

        // directed: empty dequeue, fill with ties and extremes, duplicate and full cases
        add_cmd(FUNC_DEQ, '1, '1, 0);
        for (int k = 0; k < DEPTH; k++) begin
            id = (k == 0) ? '0 : (k == 1) ? '1 : 32'hA5A5_0000 + k;
            add_cmd(FUNC_ENQ, id, fill_prios[k], k % 3);
        end
        add_cmd(FUNC_ENQ, '1, 8'd3, 0);
        add_cmd(FUNC_ENQ, 32'h5A5A_5A5A, 8'd200, 1);
        add_cmd(FUNC_DEQ, '0, '0, 0);
        add_cmd(FUNC_ENQ, '0, 8'd9, 2);
        add_cmd(FUNC_ENQ, 32'h5A5A_5A5A, 8'd255, 0);
        add_cmd(FUNC_DEQ, 32'h1234_5678, 8'd77, 0);
        add_cmd(FUNC_DEQ, '0, '0, 3);
        add_cmd(FUNC_DEQ, '1, '1, 0);

        // random: a small id pool keeps duplicates frequent, phases sweep the fill level
        foreach (id_pool[k]) id_pool[k] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        total = 0;
        while (total < 600) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0: enq_pct = 20;
                1: enq_pct = 50;
                2: enq_pct = 80;
                default: enq_pct = 95;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len; k++) begin
                id   = ($urandom_range(0, 99) < 80) ? id_pool[$urandom_range(0, 23)]
                                                   : $urandom();
                prio = $urandom_range(0, 1) ? PRIO_W'($urandom())
                                            : PRIO_W'($urandom_range(0, 3) * 85);
                add_cmd(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ, id, prio,
                        no_idle ? 0 : $urandom_range(0, 7));
            end
            total += phase_len;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all commands launched and accepted, all results seen
        @(posedge i_clk);
        while (command_queue.size() != 0 || start || awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #400us;
        $display("Regression FAIL");
        $finish;
    end

endmodule
